>>> hw/rtl/scalar_kalman_filter_defines.svh
// ---------------------------------------------------------------------------
// Scalar Kalman filter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define SKF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SKF_ASSERT_IMPL(label, ante, cons, msg)
`define SKF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/skf_pkg.sv
// ---------------------------------------------------------------------------
// Scalar Kalman filter package
// Widths, register indexes, payload types and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int GAIN_WIDTH      = FRAC_BITS + 1;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [DATA_WIDTH-1:0] ONE_DATA = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [GAIN_WIDTH-1:0] ONE_GAIN = GAIN_WIDTH'(1) << FRAC_BITS;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE     = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL_VARIANCE  = CFG_INDEX_WIDTH'(2);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] measurement;
        logic                         restart;
    } skf_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] estimate;
        logic        [DATA_WIDTH-1:0] variance;
        logic        [GAIN_WIDTH-1:0] gain;
    } skf_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } skf_unit_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_GAIN,
        S_DIV,
        S_MUL,
        S_FINISH
    } skf_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/skf_div.sv
// ---------------------------------------------------------------------------
// Bit-serial fractional divider
// Restoring long division, one quotient bit per cycle, num <= den assumed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skf_div
    import skf_pkg::*;
#(
    parameter int DEN_WIDTH = DATA_WIDTH + 1,
    parameter int Q_BITS    = FRAC_BITS + 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DEN_WIDTH-1:0] num,
    input  wire logic [DEN_WIDTH-1:0] den,
    output skf_unit_status_t          status,
    output logic      [Q_BITS-1:0]    quotient
);

    localparam int REM_WIDTH = DEN_WIDTH + 1;
    localparam int CNT_WIDTH = $clog2(Q_BITS + 1);
    localparam logic [CNT_WIDTH-1:0] LAST = CNT_WIDTH'(Q_BITS - 1);

    logic [REM_WIDTH-1:0] rem_reg;
    logic [REM_WIDTH-1:0] rem_next;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [Q_BITS-1:0]    q_reg;
    logic [Q_BITS-1:0]    q_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [REM_WIDTH-1:0] trial;
    logic [REM_WIDTH-1:0] den_ext;

    assign den_ext = {1'b0, den_reg};

    always_comb
    begin
        // the first step compares the numerator unshifted (integer bit)
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_WIDTH-2:0], 1'b0};
        if (trial >= den_ext)
        begin
            rem_next = trial - den_ext;
            q_next   = {q_reg[Q_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            q_next   = {q_reg[Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/skf_mul.sv
// ---------------------------------------------------------------------------
// Bit-serial rounding multiplier
// Shift-add over the multiplier bits, MSB first, then round half up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skf_mul
    import skf_pkg::*;
#(
    parameter int A_WIDTH    = DATA_WIDTH,
    parameter int B_WIDTH    = GAIN_WIDTH,
    parameter int ROUND_BITS = FRAC_BITS
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    input  wire logic [A_WIDTH-1:0]                        a,
    input  wire logic [B_WIDTH-1:0]                        b,
    output skf_unit_status_t                               status,
    output logic      [A_WIDTH+B_WIDTH-ROUND_BITS-1:0]     product
);

    localparam int ACC_WIDTH = A_WIDTH + B_WIDTH;
    localparam int CNT_WIDTH = $clog2(B_WIDTH + 1);
    localparam logic [CNT_WIDTH-1:0] ROUND_STEP = CNT_WIDTH'(B_WIDTH);
    localparam logic [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (ROUND_BITS - 1);

    logic [A_WIDTH-1:0]   a_reg;
    logic [B_WIDTH-1:0]   b_reg;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic [ACC_WIDTH-1:0] acc_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        if (cnt_reg == ROUND_STEP)
        begin
            acc_next = acc_reg + HALF;
        end
        else if (b_reg[B_WIDTH-1])
        begin
            acc_next = {acc_reg[ACC_WIDTH-2:0], 1'b0} + ACC_WIDTH'(a_reg);
        end
        else
        begin
            acc_next = {acc_reg[ACC_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == ROUND_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[B_WIDTH-2:0], 1'b0};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg[ACC_WIDTH-1:ROUND_BITS];

endmodule

`default_nettype wire

>>> hw/rtl/scalar_kalman_filter.sv
// ---------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional estimate and variance tracker, one measurement per word.
// ---------------------------------------------------------------------------
// Input words (measurement, restart) arrive on in_valid/in_ready; each gives
// one result word (estimate, variance, gain) on out_valid/out_ready.
// Noise and initial variance registers are written through cfg_write,
// cfg_index and cfg_data; write them only while no word is in flight.
// Each word passes the bit-serial gain divider (FRAC_BITS + 1 steps, with
// FRAC_BITS = 16) and then the two bit-serial multipliers that run side by
// side (FRAC_BITS + 1 steps plus a rounding step). A new word is taken only
// after the previous result is registered, so words do not overlap.
// The result sits in an output register, so a stalled receiver does not
// hold up the next word; if the previous result is still unread when the
// next finishes, the block waits in its last step until out_ready.
// Reset clears the estimate to zero, sets the variance to one, sets the
// noise registers to 0 and 1.0 and the initial variance to 1.0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter
    import skf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]      cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire skf_in_t                    in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output skf_out_t                        out_data
);

    localparam int W       = DATA_WIDTH;
    localparam int EST_P_W = (W + 1) + GAIN_WIDTH - FRAC_BITS;
    localparam int VAR_P_W = W + GAIN_WIDTH - FRAC_BITS;

    skf_state_t state_reg;
    skf_state_t state_next;

    logic [W-1:0] q_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] p0_reg;

    logic signed [W-1:0] est_reg;
    logic signed [W-1:0] est_next;
    logic        [W-1:0] var_reg;
    logic        [W-1:0] var_next;
    logic signed [W-1:0] z_reg;
    logic        [W-1:0] pp_reg;
    logic        [W-1:0] pp_next;
    logic        [W:0]   mag_reg;
    logic        [W:0]   mag_next;
    logic                neg_reg;
    logic                den_zero_reg;
    logic [GAIN_WIDTH-1:0] gain_reg;
    logic [GAIN_WIDTH-1:0] gain_next;

    skf_out_t out_reg;
    logic     out_valid_reg;

    logic     accept;
    logic     slot_free;
    logic     div_start;
    logic     mul_start;
    logic     finish_fire;

    logic [W:0] pred_sum;
    logic [W:0] den;
    logic [W:0] diff_pos;
    logic [W:0] diff_neg;
    logic [W:0] est_ext;
    logic [W:0] est_sum;

    skf_unit_status_t    div_status;
    skf_unit_status_t    mul_est_status;
    skf_unit_status_t    mul_var_status;
    logic [GAIN_WIDTH-1:0] quotient;
    logic [EST_P_W-1:0]  est_prod;
    logic [VAR_P_W-1:0]  var_prod;

    // configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= '0;
            r_reg  <= ONE_DATA;
            p0_reg <= ONE_DATA;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROCESS_NOISE:     q_reg  <= cfg_data;
                REG_MEASUREMENT_NOISE: r_reg  <= cfg_data;
                REG_INITIAL_VARIANCE:  p0_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_PRED;
            S_PRED:   state_next = S_GAIN;
            S_GAIN:   state_next = S_DIV;
            S_DIV:    if (div_status.done) state_next = S_MUL;
            S_MUL:    if (mul_est_status.done) state_next = S_FINISH;
            S_FINISH: if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        mul_start   = 1'b0;
        finish_fire = 1'b0;
        case (state_reg)
            S_IDLE:   in_ready    = 1'b1;
            S_GAIN:   div_start   = 1'b1;
            S_DIV:    mul_start   = div_status.done;
            S_FINISH: finish_fire = slot_free;
            default:  ;
        endcase
    end

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // prediction, saturating, and magnitude of the innovation
    assign pred_sum = {1'b0, var_reg} + {1'b0, q_reg};
    assign pp_next  = pred_sum[W] ? '1 : pred_sum[W-1:0];
    assign diff_pos = {z_reg[W-1], z_reg} - {est_reg[W-1], est_reg};
    assign diff_neg = {est_reg[W-1], est_reg} - {z_reg[W-1], z_reg};
    assign mag_next = (z_reg < est_reg) ? diff_neg : diff_pos;

    assign den = {1'b0, pp_reg} + {1'b0, r_reg};

    // zero denominator forces a zero gain
    assign gain_next = den_zero_reg ? '0 : quotient;

    // estimate moves by the rounded adjustment toward the measurement
    assign est_ext  = {est_reg[W-1], est_reg};
    assign est_sum  = neg_reg ? est_ext - est_prod[W:0] : est_ext + est_prod[W:0];
    assign est_next = est_sum[W-1:0];
    assign var_next = var_prod[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            est_reg       <= '0;
            var_reg       <= ONE_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && in_data.restart)
            begin
                est_reg <= in_data.measurement;
                var_reg <= p0_reg;
            end
            else if (finish_fire)
            begin
                est_reg <= est_next;
                var_reg <= var_next;
            end
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            z_reg <= in_data.measurement;
        end
        if (state_reg == S_PRED)
        begin
            pp_reg  <= pp_next;
            mag_reg <= mag_next;
            neg_reg <= (z_reg < est_reg);
        end
        if (div_start)
        begin
            den_zero_reg <= (den == '0);
        end
        if (mul_start)
        begin
            gain_reg <= gain_next;
        end
        if (finish_fire)
        begin
            out_reg.estimate <= est_next;
            out_reg.variance <= var_next;
            out_reg.gain     <= gain_reg;
        end
    end

    skf_div #(
        .DEN_WIDTH (W + 1),
        .Q_BITS    (GAIN_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      ({1'b0, pp_reg}),
        .den      (den),
        .status   (div_status),
        .quotient (quotient)
    );

    skf_mul #(
        .A_WIDTH    (W + 1),
        .B_WIDTH    (GAIN_WIDTH),
        .ROUND_BITS (FRAC_BITS)
    ) u_mul_est (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag_reg),
        .b       (gain_next),
        .status  (mul_est_status),
        .product (est_prod)
    );

    skf_mul #(
        .A_WIDTH    (W),
        .B_WIDTH    (GAIN_WIDTH),
        .ROUND_BITS (FRAC_BITS)
    ) u_mul_var (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (pp_reg),
        .b       (ONE_GAIN - gain_next),
        .status  (mul_var_status),
        .product (var_prod)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SKF_ASSERT_IMPL(a_div_done_in_div, div_status.done, state_reg == S_DIV, "stray divide")
    `SKF_ASSERT_IMPL(a_mul_in_step, 1'b1, mul_est_status.done == mul_var_status.done, "mul skew")
    `SKF_ASSERT_IMPL(a_gain_le_one, out_valid_reg, out_reg.gain <= ONE_GAIN, "gain above one")
    `SKF_ASSERT_IMPL(a_var_not_grown, finish_fire, var_next <= pp_reg, "variance grew")
    `SKF_ASSERT_NEXT(a_result_held, finish_fire, out_valid_reg, "result not registered")

endmodule

`default_nettype wire

>>> verif/tb_scalar_kalman_filter.sv
// ---------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives measurement words through the filter under random handshake gaps and
// checks every result word (estimate, variance, gain) against a cycle-free
// predictor of the filter kept in step with the noise settings written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_scalar_kalman_filter;

    import skf_pkg::*;

    localparam int          CLK_HALF_NS      = 4;
    localparam int          LATENCY          = 2 * FRAC_BITS + 8;
    localparam int          LONG_HOLD_CYCLES = 600;
    localparam int          RANDOM_BLOCKS    = 6;
    localparam int          BLOCK_WORDS      = 150;
    localparam longint      TIMEOUT_NS       = 64'd4_000_000;
    localparam logic [63:0] GAIN_ONE_W       = 64'(ONE_GAIN);
    localparam logic [63:0] ROUND_HALF       = GAIN_ONE_W >> 1;
    localparam logic [DATA_WIDTH-1:0] DATA_MAX = '1;
    localparam logic [63:0] DATA_MAX_W       = 64'(DATA_MAX);

    // index with no register behind it
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = CFG_INDEX_WIDTH'(3);

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [DATA_WIDTH-1:0]      cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    skf_in_t                    in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    skf_out_t                   out_data;

    // filter state and settings as the predictor sees them
    logic signed [DATA_WIDTH-1:0] track_estimate = '0;
    logic        [DATA_WIDTH-1:0] track_variance = ONE_DATA;
    logic        [DATA_WIDTH-1:0] noise_q        = '0;
    logic        [DATA_WIDTH-1:0] noise_r        = ONE_DATA;
    logic        [DATA_WIDTH-1:0] start_variance = ONE_DATA;

    skf_out_t pending_results[$];

    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    bit          long_hold_req   = 1'b0;
    int unsigned error_count     = 0;
    int unsigned words_sent      = 0;
    int unsigned restarts_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used   = 0;

    scalar_kalman_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #(CLK_HALF_NS) clk = ~clk;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("tb_scalar_kalman_filter NOT OK");
        $finish;
    end

    // One filter step: predict, gain, estimate update, variance update.
    function automatic skf_out_t kalman_update(input skf_in_t w);
        logic        [63:0] pred_var;
        logic        [63:0] denom;
        logic        [63:0] k;
        logic        [63:0] mag;
        logic        [63:0] step;
        logic        [63:0] var_next;
        logic signed [63:0] z;
        logic signed [63:0] x;
        logic signed [63:0] diff;
        skf_out_t           r;
        if (w.restart)
        begin
            track_estimate = w.measurement;
            track_variance = start_variance;
        end
        z        = {{(64-DATA_WIDTH){w.measurement[DATA_WIDTH-1]}}, w.measurement};
        x        = {{(64-DATA_WIDTH){track_estimate[DATA_WIDTH-1]}}, track_estimate};
        pred_var = 64'(track_variance) + 64'(noise_q);
        if (pred_var > DATA_MAX_W)
            pred_var = DATA_MAX_W;
        denom = pred_var + 64'(noise_r);
        k     = (denom == 64'd0) ? 64'd0 : (pred_var << FRAC_BITS) / denom;
        if (k > GAIN_ONE_W)
            k = GAIN_ONE_W;
        diff = z - x;
        mag  = diff[63] ? 64'(-diff) : 64'(diff);
        // magnitude rounded half away from zero, then reapply the sign
        step = (mag * k + ROUND_HALF) >> FRAC_BITS;
        x    = diff[63] ? x - $signed(step) : x + $signed(step);
        var_next       = (pred_var * (GAIN_ONE_W - k) + ROUND_HALF) >> FRAC_BITS;
        track_estimate = x[DATA_WIDTH-1:0];
        track_variance = var_next[DATA_WIDTH-1:0];
        r.estimate     = track_estimate;
        r.variance     = track_variance;
        r.gain         = k[GAIN_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: MISMATCH %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one word, hold it until taken, then log its expected result.
    task automatic send_word(input logic signed [DATA_WIDTH-1:0] meas, input logic restart);
        skf_in_t w;
        w.measurement = meas;
        w.restart     = restart;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.insert(pending_results.size(), kalman_update(w));
        words_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // Stop offering, wait for every result, then let the datapath settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // Write all registers plus the unused index; only call while idle.
    task automatic program_filter(input logic [DATA_WIDTH-1:0] q,
                                  input logic [DATA_WIDTH-1:0] r,
                                  input logic [DATA_WIDTH-1:0] p0);
        cfg_write <= 1'b1;
        cfg_index <= REG_PROCESS_NOISE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= REG_MEASUREMENT_NOISE;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_INITIAL_VARIANCE;
        cfg_data  <= p0;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_index <= REG_PROCESS_NOISE;
        noise_q        = q;
        noise_r        = r;
        start_variance = p0;
        settings_used++;
    endtask

    // Result side: check each word taken, then pick the next out_ready.
    initial
    begin : result_sink
        int unsigned hold_left;
        skf_out_t    want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result word", 64'(out_data), 64'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.estimate !== want.estimate)
                        report_mismatch("estimate", 64'(out_data.estimate), 64'(want.estimate));
                    if (out_data.variance !== want.variance)
                        report_mismatch("variance", 64'(out_data.variance), 64'(want.variance));
                    if (out_data.gain !== want.gain)
                        report_mismatch("gain", 64'(out_data.gain), 64'(want.gain));
                end
            end
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Reset state: estimate zero, variance one, Q zero, R one.
    task automatic test_reset_state();
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(-32'sd1, 1'b0);
    endtask

    task automatic test_restart_extremes();
        drain_results();
        program_filter(ONE_DATA >> 4, ONE_DATA << 2, ONE_DATA << 3);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
    endtask

    // No measurement noise: gain is exactly one and the estimate follows z.
    task automatic test_exact_measurement();
        drain_results();
        program_filter(ONE_DATA >> 1, '0, ONE_DATA);
        send_word(32'sh0001_8000, 1'b1);
        send_word(-32'sh0123_4567, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
    endtask

    // Zero predicted variance and zero R: gain zero, estimate held.
    task automatic test_zero_denominator();
        drain_results();
        program_filter('0, '0, '0);
        send_word(32'sh0005_0000, 1'b1);
        send_word(-32'sh0003_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
    endtask

    // Maximum Q and initial variance: predicted variance saturates.
    task automatic test_variance_saturation();
        drain_results();
        program_filter(DATA_MAX, DATA_MAX, DATA_MAX);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh0000_0001, 1'b0);
        send_word(-32'sd1, 1'b0);
    endtask

    // Long receiver hold-off so the block fills up, then a full sender pause.
    task automatic test_output_backpressure();
        drain_results();
        program_filter(ONE_DATA >> 3, ONE_DATA, ONE_DATA);
        send_idle_pct = 0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_word($urandom, i == 0);
        drain_results();
        for (int i = 0; i < 4; i++)
            send_word($urandom, 1'b0);
    endtask

    // Tracking streams: a drifting signal plus noise, with stray words and restarts.
    task automatic test_random_tracking(input int blocks_run, input int unsigned send_pct,
                                        input int unsigned recv_pct);
        logic        [DATA_WIDTH-1:0] q;
        logic        [DATA_WIDTH-1:0] r;
        logic        [DATA_WIDTH-1:0] p0;
        logic signed [DATA_WIDTH-1:0] truth;
        logic signed [DATA_WIDTH-1:0] jitter;
        logic signed [DATA_WIDTH-1:0] meas;
        for (int blk = 0; blk < blocks_run; blk++)
        begin
            drain_results();
            case ($urandom_range(5))
                0:
                begin
                    q  = $urandom;
                    r  = $urandom;
                    p0 = $urandom;
                end
                1:
                begin
                    q  = $urandom_range(0, ONE_DATA >> 4);
                    r  = $urandom_range(ONE_DATA >> 2, ONE_DATA << 4);
                    p0 = $urandom_range(0, ONE_DATA << 2);
                end
                2:
                begin
                    q  = $urandom_range(0, ONE_DATA);
                    r  = '0;
                    p0 = $urandom;
                end
                3:
                begin
                    q  = DATA_MAX;
                    r  = $urandom;
                    p0 = DATA_MAX;
                end
                4:
                begin
                    q  = '0;
                    r  = $urandom_range(0, 3);
                    p0 = $urandom_range(0, 3);
                end
                default:
                begin
                    q  = $urandom_range(0, 255);
                    r  = $urandom_range(1, 255);
                    p0 = $urandom_range(0, 255);
                end
            endcase
            program_filter(q, r, p0);
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            truth = $urandom;
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                jitter = ($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000)
                         <<< $urandom_range(0, 12);
                case ($urandom_range(9))
                    0: meas = $urandom;
                    1:
                    begin
                        case ($urandom_range(3))
                            0: meas = 32'sh7FFF_FFFF;
                            1: meas = 32'sh8000_0000;
                            2: meas = '0;
                            default: meas = -32'sd1;
                        endcase
                    end
                    default:
                    begin
                        truth = truth + (jitter >>> 4);
                        meas  = truth + jitter;
                    end
                endcase
                send_word(meas, $urandom_range(19) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_restart_extremes();
        test_exact_measurement();
        test_zero_denominator();
        test_variance_saturation();
        test_output_backpressure();

        test_random_tracking(RANDOM_BLOCKS / 3, 33, 46);
        test_random_tracking(RANDOM_BLOCKS / 3, 46, 33);
        test_random_tracking(RANDOM_BLOCKS - 2 * (RANDOM_BLOCKS / 3), 0, 0);

        drain_results();
        $display("Covered %0d measurement words (%0d restarts) across %0d noise settings,",
                 words_sent, restarts_sent, settings_used);
        $display("%0d result words checked, including a long output stall and gain extremes",
                 results_checked);
        if (error_count == 0)
            $display("tb_scalar_kalman_filter OK");
        else
            $display("tb_scalar_kalman_filter NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/skf_pkg.sv
hw/rtl/skf_div.sv
hw/rtl/skf_mul.sv
hw/rtl/scalar_kalman_filter.sv
verif/tb_scalar_kalman_filter.sv
